// File: sv/lspd_pkg.sv
// ----------------------------------------------------------------------------
// lspd_pkg
// Shared constants, types and the CORDIC arctangent table for the lidar
// scan packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lspd_pkg;

	localparam int LSPD_CORR_TABLE_DEPTH = 1024;
	localparam int LSPD_ANGLE_FRAC_BITS  = 6;

	// configuration register reset values
	localparam logic [15:0] PACKET_HEADER_RST = 16'h55AA;
	localparam logic [15:0] INFO_HEADER_RST   = 16'hA55A;
	localparam logic [7:0]  INFO_SKIP_LEN_RST = 8'd25;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PACKET_HEADER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INFO_HEADER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INFO_SKIP_LEN = 2'd2;

	// CORDIC arctangent in Q16 degrees
	localparam int CORDIC_IDX_W = 4;
	localparam int ATAN_W       = 22;
	localparam int Z_W          = 25;

	function automatic logic [ATAN_W-1:0] atan_deg_q16(input logic [CORDIC_IDX_W-1:0] i);
		logic [ATAN_W-1:0] v;
		case (i)
			4'd0:    v = 22'd2949120;
			4'd1:    v = 22'd1740967;
			4'd2:    v = 22'd919879;
			4'd3:    v = 22'd466945;
			4'd4:    v = 22'd234379;
			4'd5:    v = 22'd117304;
			4'd6:    v = 22'd58666;
			4'd7:    v = 22'd29335;
			4'd8:    v = 22'd14668;
			4'd9:    v = 22'd7334;
			4'd10:   v = 22'd3667;
			4'd11:   v = 22'd1833;
			4'd12:   v = 22'd917;
			4'd13:   v = 22'd458;
			4'd14:   v = 22'd229;
			4'd15:   v = 22'd115;
			default: v = '0;
		endcase
		return v;
	endfunction

	typedef struct packed {
		logic rx_open;
		logic ld_prev;
		logic ld_lsn;
		logic ld_fsa_lo;
		logic ld_fsa_hi;
		logic ld_lsa_lo;
		logic ld_lsa_hi;
		logic ld_dlo;
		logic ld_dist;
		logic clr_cnt;
		logic prep1;
		logic prep2;
		logic prep3;
		logic div_start;
		logic div_sel;     // 0: angle interpolation, 1: correction ratio
		logic ld_base;
		logic cordic_init;
		logic cordic_step;
		logic ld_total;
		logic wrap_step;
		logic ld_out;
	} lspd_cmd_t;

	typedef struct packed {
		logic       hdr_info;
		logic       hdr_pkt;
		logic [7:0] skip_rem;
		logic       lsn_zero;
		logic       last;
		logic       div_done;
		logic       cordic_last;
		logic       wrap_done;
		logic       out_free;
	} lspd_sts_t;

endpackage

`default_nettype wire

// File: sv/lidar_scan_packet_decoder.sv
// ----------------------------------------------------------------------------
// lidar_scan_packet_decoder
// Parses the lidar serial byte stream and emits one result per scan sample.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (rx_byte, rx_valid, rx_stall): one stream byte per transfer.
//   sample channel (distance_raw, angle_q6, angle_bin, sample_number,
//   last_in_packet, sample_valid, sample_stall): one result per sample.
//   cfg channel (cfg_index, cfg_data, cfg_valid, cfg_ready): header values
//   and info skip length; cfg_ready is always high. Write only while idle.
//   Header, info and first distance bytes never stall the sender. The second
//   distance byte starts the sample computation, during which rx_stall is
//   high: the prep steps, two divides on one shared radix-2 divider of
//   NUM_W = 31 + clog2(CORR_TABLE_DEPTH+1) bits, the CORDIC iterations,
//   the sum, the wrap steps into one turn and the result load.
//   The result sits in an output register; the parser keeps taking bytes
//   while it waits, and only the next result waits if it is still stalled.
//   Reset: registers go to their defaults and the parser hunts for a header.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_scan_packet_decoder import lspd_pkg::*; #(
	parameter int CORR_TABLE_DEPTH = LSPD_CORR_TABLE_DEPTH,
	parameter int ANGLE_FRAC_BITS  = LSPD_ANGLE_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [7:0]           rx_byte,
	input  wire logic                 rx_valid,
	output logic                      rx_stall,
	output logic [15:0]               distance_raw,
	output logic [14:0]               angle_q6,
	output logic [8:0]                angle_bin,
	output logic [7:0]                sample_number,
	output logic                      last_in_packet,
	output logic                      sample_valid,
	input  wire logic                 sample_stall,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready
);

	logic [15:0] packet_header_q;
	logic [15:0] info_header_q;
	logic [7:0]  info_skip_len_q;
	lspd_cmd_t   cmd;
	lspd_sts_t   sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_header_q <= PACKET_HEADER_RST;
			info_header_q   <= INFO_HEADER_RST;
			info_skip_len_q <= INFO_SKIP_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PACKET_HEADER: packet_header_q <= cfg_data;
				CFG_INFO_HEADER:   info_header_q   <= cfg_data;
				CFG_INFO_SKIP_LEN: info_skip_len_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lspd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_valid(rx_valid),
		.sts     (sts),
		.cmd     (cmd)
	);

	lspd_dp #(
		.CORR_TABLE_DEPTH(CORR_TABLE_DEPTH),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.rx_byte       (rx_byte),
		.packet_header (packet_header_q),
		.info_header   (info_header_q),
		.info_skip_len (info_skip_len_q),
		.sample_stall  (sample_stall),
		.sample_valid  (sample_valid),
		.distance_raw  (distance_raw),
		.angle_q6      (angle_q6),
		.angle_bin     (angle_bin),
		.sample_number (sample_number),
		.last_in_packet(last_in_packet)
	);

	assign rx_stall = !cmd.rx_open;

endmodule

`default_nettype wire

// File: sv/lspd_div.sv
// ----------------------------------------------------------------------------
// lspd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lspd_div #(
	parameter int NUM_W = 42,
	parameter int DEN_W = 30
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             ge;

	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = ~rem_sub[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");

endmodule

`default_nettype wire

// File: sv/lspd_dp.sv
// ----------------------------------------------------------------------------
// lspd_dp
// Datapath: packet fields, angle interpolation, triangulation correction by
// CORDIC, wrap into one turn and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lspd_dp import lspd_pkg::*; #(
	parameter int CORR_TABLE_DEPTH = LSPD_CORR_TABLE_DEPTH,
	parameter int ANGLE_FRAC_BITS  = LSPD_ANGLE_FRAC_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lspd_cmd_t   cmd,
	output lspd_sts_t        sts,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [15:0] packet_header,
	input  wire logic [15:0] info_header,
	input  wire logic [7:0]  info_skip_len,
	input  wire logic        sample_stall,
	output logic             sample_valid,
	output logic [15:0]      distance_raw,
	output logic [14:0]      angle_q6,
	output logic [8:0]       angle_bin,
	output logic [7:0]       sample_number,
	output logic             last_in_packet
);

	localparam int FULL       = 360 << ANGLE_FRAC_BITS;
	localparam int RIGHT      = 90 << ANGLE_FRAC_BITS;
	localparam int DW         = $clog2(FULL + 32768);
	localparam int TW         = $clog2(32768 + FULL + RIGHT) + 2;
	localparam int QW         = $clog2(CORR_TABLE_DEPTH + 1);
	localparam int CW         = $clog2(CORR_TABLE_DEPTH) + 20;
	localparam int SH         = 16 - ANGLE_FRAC_BITS;
	localparam int ROUND_HALF = 1 << (SH - 1);
	localparam int NUM_W      = 31 + QW;
	localparam int DEN_W      = 30;
	localparam int PW         = DW + 8;

	// packet fields
	logic [7:0]  prev_q;
	logic [7:0]  lsn_q;
	logic [15:0] fsa_q;
	logic [15:0] lsa_q;
	logic [7:0]  dlo_q;
	logic [15:0] dist_q;
	logic [7:0]  cnt_q;
	logic        last_q;

	// preparation
	logic signed [20:0] t_q;
	logic [29:0]        b_q;
	logic [DW-1:0]      diff_q;
	logic               diff_neg_q;
	logic [7:0]         nm1_q;
	logic [7:0]         bden_q;
	logic               neg_q;
	logic [29:0]        a_q;
	logic [PW-1:0]      prod_q;
	logic               le_q;
	logic [NUM_W-1:0]   qnum_q;
	logic [DEN_W-1:0]   qden_q;
	logic signed [TW-1:0] base_q;

	// CORDIC
	logic signed [CW-1:0]  x_q;
	logic signed [CW-1:0]  y_q;
	logic signed [Z_W-1:0] z_q;
	logic [CORDIC_IDX_W-1:0] idx_q;

	logic signed [TW-1:0] total_q;
	logic                 ov_q;

	// combinational
	logic [15:0]          hdr;
	logic [19:0]          d10;
	logic signed [DW:0]   dr;
	logic signed [DW:0]   dfix;
	logic [20:0]          t_abs;
	logic [29:0]          p_sel;
	logic [29:0]          r_sel;
	logic                 a_le_b;
	logic [NUM_W-1:0]     dnum;
	logic [DEN_W-1:0]     dden;
	logic                 ddone;
	logic [NUM_W-1:0]     dquot;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] y_mag;
	logic signed [Z_W-1:0] at_s;
	logic signed [Z_W-1:0] zr;
	logic signed [Z_W-1:0] zr_mag;
	logic signed [Z_W-1:0] tr;
	logic signed [Z_W-1:0] mag;
	logic signed [Z_W-1:0] corr;
	logic signed [TW-1:0]  total_n;
	logic                  out_free;

	assign hdr = {prev_q, rx_byte};
	assign d10 = {4'b0, dist_q} * 20'd10;

	assign dr   = $signed((DW+1)'(lsa_q[15:1])) - $signed((DW+1)'(fsa_q[15:1]));
	assign dfix = dr[DW] ? dr + $signed((DW+1)'(FULL)) : dr;

	assign t_abs  = t_q[20] ? (~t_q + 1'b1) : t_q;
	assign a_le_b = a_q <= b_q;
	assign p_sel  = a_le_b ? a_q : b_q;
	assign r_sel  = a_le_b ? b_q : a_q;

	assign dnum = cmd.div_sel ? qnum_q : NUM_W'(prod_q);
	assign dden = cmd.div_sel ? qden_q : DEN_W'(bden_q);

	lspd_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (dnum),
		.den   (dden),
		.done  (ddone),
		.quot  (dquot)
	);

	// x never goes negative; y needs a symmetric shift
	assign xs    = x_q >>> idx_q;
	assign y_mag = -y_q;
	assign ys    = y_q[CW-1] ? -(y_mag >>> idx_q) : (y_q >>> idx_q);
	assign at_s  = $signed(Z_W'(atan_deg_q16(idx_q)));

	assign zr      = z_q + $signed(Z_W'(ROUND_HALF));
	assign zr_mag  = -zr;
	assign tr      = zr[Z_W-1] ? -(zr_mag >>> SH) : (zr >>> SH);
	assign mag     = le_q ? tr : $signed(Z_W'(RIGHT)) - tr;
	assign corr    = (dist_q == 16'd0) ? '0 : (neg_q ? -mag : mag);
	assign total_n = base_q + $signed(TW'(corr));

	assign out_free = !ov_q || !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
			idx_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (cmd.ld_dist) begin
				cnt_q  <= cnt_q + 1'b1;
				last_q <= ({1'b0, cnt_q} + 9'd1) >= {1'b0, lsn_q};
			end
			if (cmd.cordic_init) begin
				idx_q <= '0;
			end else if (cmd.cordic_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.ld_out) begin
				ov_q <= 1'b1;
			end else if (!sample_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_prev)   prev_q       <= rx_byte;
		if (cmd.ld_lsn)    lsn_q        <= rx_byte;
		if (cmd.ld_fsa_lo) fsa_q[7:0]   <= rx_byte;
		if (cmd.ld_fsa_hi) fsa_q[15:8]  <= rx_byte;
		if (cmd.ld_lsa_lo) lsa_q[7:0]   <= rx_byte;
		if (cmd.ld_lsa_hi) lsa_q[15:8]  <= rx_byte;
		if (cmd.ld_dlo)    dlo_q        <= rx_byte;
		if (cmd.ld_dist)   dist_q       <= {rx_byte, dlo_q};
		if (cmd.prep1) begin
			t_q        <= 21'sd6212 - $signed({1'b0, d10});
			b_q        <= {14'b0, dist_q} * 30'd15530;
			// angle words past one turn can leave the span negative; keep sign
			// and magnitude so the divide truncates toward zero
			diff_neg_q <= dfix[DW];
			diff_q     <= dfix[DW] ? DW'(-dfix) : dfix[DW-1:0];
			nm1_q      <= cnt_q - 1'b1;
			bden_q     <= (lsn_q > 8'd1) ? lsn_q - 1'b1 : 8'd1;
		end
		if (cmd.prep2) begin
			neg_q  <= t_q[20];
			a_q    <= {9'b0, t_abs} * 30'd218;
			prod_q <= PW'(diff_q) * PW'(nm1_q);
		end
		if (cmd.prep3) begin
			le_q   <= a_le_b;
			qnum_q <= NUM_W'(p_sel) * NUM_W'(CORR_TABLE_DEPTH) + NUM_W'(r_sel >> 1);
			qden_q <= r_sel;
		end
		if (cmd.ld_base) begin
			base_q <= $signed(TW'(fsa_q[15:1])) +
				(diff_neg_q ? -$signed(TW'(dquot)) : $signed(TW'(dquot)));
		end
		if (cmd.cordic_init) begin
			x_q <= $signed(CW'(CORR_TABLE_DEPTH)) <<< 16;
			y_q <= $signed(CW'(dquot[QW-1:0])) <<< 16;
			z_q <= '0;
		end else if (cmd.cordic_step) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at_s;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at_s;
			end
		end
		if (cmd.ld_total) begin
			total_q <= total_n;
		end else if (cmd.wrap_step) begin
			if (total_q[TW-1]) begin
				total_q <= total_q + $signed(TW'(FULL));
			end else begin
				total_q <= total_q - $signed(TW'(FULL));
			end
		end
		if (cmd.ld_out) begin
			distance_raw   <= dist_q;
			angle_q6       <= total_q[14:0];
			angle_bin      <= total_q[ANGLE_FRAC_BITS +: 9];
			sample_number  <= cnt_q;
			last_in_packet <= last_q;
		end
	end

	assign sample_valid = ov_q;

	always_comb begin
		sts             = '0;
		sts.hdr_info    = hdr == info_header;
		sts.hdr_pkt     = hdr == packet_header;
		sts.skip_rem    = (info_skip_len < 8'd2) ? 8'd0 : info_skip_len - 8'd2;
		sts.lsn_zero    = lsn_q == 8'd0;
		sts.last        = last_q;
		sts.div_done    = ddone;
		sts.cordic_last = idx_q == '1;
		sts.wrap_done   = !total_q[TW-1] && (total_q < $signed(TW'(FULL)));
		sts.out_free    = out_free;
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> !(ov_q && sample_stall)) else $error("pending result overwritten");
	a_angle_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> (!total_q[TW-1] && total_q < $signed(TW'(FULL))))
		else $error("angle not wrapped at result load");

endmodule

`default_nettype wire

// File: sv/lspd_ctrl.sv
// ----------------------------------------------------------------------------
// lspd_ctrl
// Controller: byte stream parser and per-sample compute sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lspd_ctrl import lspd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      rx_valid,
	input  wire lspd_sts_t sts,
	output lspd_cmd_t      cmd
);

	typedef enum logic [4:0] {
		ST_HUNT_EMPTY,
		ST_HUNT_HELD,
		ST_SKIP,
		ST_HEADER,
		ST_DIST_LO,
		ST_DIST_HI,
		ST_PREP1,
		ST_PREP2,
		ST_PREP3,
		ST_BDIV_GO,
		ST_BDIV_WAIT,
		ST_QDIV_GO,
		ST_QDIV_WAIT,
		ST_CORDIC,
		ST_TOTAL,
		ST_WRAP,
		ST_EMIT
	} state_t;

	// byte positions after the scan header
	localparam logic [7:0] HB_LSN    = 8'd1;
	localparam logic [7:0] HB_FSA_LO = 8'd2;
	localparam logic [7:0] HB_FSA_HI = 8'd3;
	localparam logic [7:0] HB_LSA_LO = 8'd4;
	localparam logic [7:0] HB_LSA_HI = 8'd5;
	localparam logic [7:0] HB_LAST   = 8'd7;

	state_t     state_q, state_d;
	logic [7:0] hb_q, hb_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		hb_d    = hb_q;
		case (state_q)
			ST_HUNT_EMPTY: begin
				cmd.rx_open = 1'b1;
				if (rx_valid) begin
					cmd.ld_prev = 1'b1;
					state_d     = ST_HUNT_HELD;
				end
			end
			ST_HUNT_HELD: begin
				cmd.rx_open = 1'b1;
				if (rx_valid) begin
					cmd.ld_prev = 1'b1;
					if (sts.hdr_info) begin
						hb_d    = sts.skip_rem;
						state_d = (sts.skip_rem == 8'd0) ? ST_HUNT_EMPTY : ST_SKIP;
					end else if (sts.hdr_pkt) begin
						hb_d    = '0;
						state_d = ST_HEADER;
					end
				end
			end
			ST_SKIP: begin
				cmd.rx_open = 1'b1;
				if (rx_valid) begin
					hb_d = hb_q - 1'b1;
					if (hb_q == 8'd1) state_d = ST_HUNT_EMPTY;
				end
			end
			ST_HEADER: begin
				cmd.rx_open = 1'b1;
				if (rx_valid) begin
					case (hb_q)
						HB_LSN:    cmd.ld_lsn    = 1'b1;
						HB_FSA_LO: cmd.ld_fsa_lo = 1'b1;
						HB_FSA_HI: cmd.ld_fsa_hi = 1'b1;
						HB_LSA_LO: cmd.ld_lsa_lo = 1'b1;
						HB_LSA_HI: cmd.ld_lsa_hi = 1'b1;
						default: ;
					endcase
					hb_d = hb_q + 1'b1;
					if (hb_q >= HB_LAST) begin
						cmd.clr_cnt = 1'b1;
						state_d     = sts.lsn_zero ? ST_HUNT_EMPTY : ST_DIST_LO;
					end
				end
			end
			ST_DIST_LO: begin
				cmd.rx_open = 1'b1;
				if (rx_valid) begin
					cmd.ld_dlo = 1'b1;
					state_d    = ST_DIST_HI;
				end
			end
			ST_DIST_HI: begin
				cmd.rx_open = 1'b1;
				if (rx_valid) begin
					cmd.ld_dist = 1'b1;
					state_d     = ST_PREP1;
				end
			end
			ST_PREP1: begin
				cmd.prep1 = 1'b1;
				state_d   = ST_PREP2;
			end
			ST_PREP2: begin
				cmd.prep2 = 1'b1;
				state_d   = ST_PREP3;
			end
			ST_PREP3: begin
				cmd.prep3 = 1'b1;
				state_d   = ST_BDIV_GO;
			end
			ST_BDIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_BDIV_WAIT;
			end
			ST_BDIV_WAIT: begin
				if (sts.div_done) begin
					cmd.ld_base = 1'b1;
					state_d     = ST_QDIV_GO;
				end
			end
			ST_QDIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_d       = ST_QDIV_WAIT;
			end
			ST_QDIV_WAIT: begin
				if (sts.div_done) begin
					cmd.cordic_init = 1'b1;
					state_d         = ST_CORDIC;
				end
			end
			ST_CORDIC: begin
				cmd.cordic_step = 1'b1;
				if (sts.cordic_last) state_d = ST_TOTAL;
			end
			ST_TOTAL: begin
				cmd.ld_total = 1'b1;
				state_d      = ST_WRAP;
			end
			ST_WRAP: begin
				if (sts.wrap_done) begin
					state_d = ST_EMIT;
				end else begin
					cmd.wrap_step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.ld_out = 1'b1;
					state_d    = sts.last ? ST_HUNT_EMPTY : ST_DIST_LO;
				end
			end
			default: state_d = ST_HUNT_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT_EMPTY;
			hb_q    <= '0;
		end else begin
			state_q <= state_d;
			hb_q    <= hb_d;
		end
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_BDIV_WAIT || state_q == ST_QDIV_WAIT))
		else $error("divider result arrived outside a wait state");
	a_closed_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_dist |=> !cmd.rx_open) else $error("input opened during sample compute");

endmodule

`default_nettype wire

// File: tb/sv/lidar_scan_packet_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_packet_decoder_tb
// Feeds byte streams of scan packets, info packets and line noise into the
// decoder under random sender gaps and receiver stalls. A predictor of the
// parser and the angle arithmetic builds the expected samples, and every
// sample transfer is compared field by field against them.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_scan_packet_decoder_tb;
	import lspd_pkg::*;

	localparam int  FRAC       = LSPD_ANGLE_FRAC_BITS;
	localparam int  DEPTH      = LSPD_CORR_TABLE_DEPTH;
	localparam int  SETTLE     = 200;
	localparam int  HOLD_LEN   = 3000;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef enum logic [2:0] {
		HUNT_EMPTY, HUNT_HELD, SKIP_INFO, READ_HEADER, DIST_LO, DIST_HI
	} parse_t;

	typedef struct {
		logic [15:0] dist_raw;
		logic [14:0] angle;
		logic [8:0]  bin;
		logic [7:0]  num;
		logic        last;
	} sample_t;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		sample_t    r;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic [7:0]        rx_byte = '0;
	logic              rx_valid = 1'b0;
	logic              rx_stall;
	logic [15:0]       distance_raw;
	logic [14:0]       angle_q6;
	logic [8:0]        angle_bin;
	logic [7:0]        sample_number;
	logic              last_in_packet;
	logic              sample_valid;
	logic              sample_stall = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]       cfg_data = '0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;

	lidar_scan_packet_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.rx_byte(rx_byte), .rx_valid(rx_valid), .rx_stall(rx_stall),
		.distance_raw(distance_raw), .angle_q6(angle_q6), .angle_bin(angle_bin),
		.sample_number(sample_number), .last_in_packet(last_in_packet),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor copy of registers and parser state
	logic [15:0] scan_hdr = PACKET_HEADER_RST;
	logic [15:0] info_hdr = INFO_HEADER_RST;
	logic [7:0]  skip_len = INFO_SKIP_LEN_RST;
	parse_t      phase = HUNT_EMPTY;
	logic [7:0]  prev_b = '0, hdr_cnt = '0, lsn = '0, smp_cnt = '0, dist_lo = '0;
	logic [15:0] fsa = '0, lsa = '0;

	sample_t     expected_samples[$];
	int          errors = 0;
	longint      cycles = 0;
	int          hold_cycles = 0;
	int          bytes_sent = 0, samples_seen = 0, scan_pkts = 0, info_pkts = 0;

	longint atan_q16[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
		29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

	function automatic longint shift_sym(longint v, int s);
		return (v >= 0) ? (v >>> s) : -((-v) >>> s);
	endfunction

	// atan(q/DEPTH) in 1/2^FRAC degree via 16-step CORDIC
	function automatic longint atan_entry(longint q);
		longint x, y, z, xs, ys;
		x = longint'(DEPTH) * 65536;
		y = q * 65536;
		z = 0;
		for (int i = 0; i < 16; i++) begin
			xs = shift_sym(x, i);
			ys = shift_sym(y, i);
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + atan_q16[i];
			end else begin
				x = x - ys; y = y + xs; z = z - atan_q16[i];
			end
		end
		return shift_sym(z + (longint'(1) << (15 - FRAC)), 16 - FRAC);
	endfunction

	function automatic longint triang_corr(longint d);
		longint num, a, b, q, c;
		if (d == 0)
			return 0;
		num = 218 * (6212 - 10 * d);
		a = (num < 0) ? -num : num;
		b = 15530 * d;
		if (a <= b) begin
			q = (a * DEPTH + b / 2) / b;
			c = atan_entry(q);
		end else begin
			q = (b * DEPTH + a / 2) / a;
			c = (longint'(90) << FRAC) - atan_entry(q);
		end
		return (num < 0) ? -c : c;
	endfunction

	function automatic sample_t build_sample(logic [15:0] d);
		longint full, f, l, base, diff, total;
		sample_t s;
		full = longint'(360) << FRAC;
		f = longint'(fsa >> 1);
		l = longint'(lsa >> 1);
		base = f;
		if (lsn > 1) begin
			diff = l - f;
			if (diff < 0)
				diff += full;
			base = f + diff * longint'(smp_cnt - 1) / longint'(lsn - 1);
		end
		total = base + triang_corr(longint'(d));
		total = ((total % full) + full) % full;
		s.dist_raw = d;
		s.angle = total[14:0];
		s.bin   = total[FRAC +: 9];
		s.num   = smp_cnt;
		s.last  = (smp_cnt >= lsn);
		return s;
	endfunction

	// advance the parser by one accepted byte; returns 1 when a sample results
	function automatic bit parse_byte(logic [7:0] b, output sample_t s);
		logic [15:0] hdr;
		logic [7:0]  rem;
		s = '{default: '0};
		case (phase)
			HUNT_EMPTY: begin
				prev_b = b;
				phase = HUNT_HELD;
			end
			HUNT_HELD: begin
				hdr = {prev_b, b};
				prev_b = b;
				if (hdr == info_hdr) begin
					rem = (skip_len < 2) ? 8'd0 : skip_len - 8'd2;
					hdr_cnt = rem;
					phase = (rem == 0) ? HUNT_EMPTY : SKIP_INFO;
				end else if (hdr == scan_hdr) begin
					hdr_cnt = '0;
					phase = READ_HEADER;
				end
			end
			SKIP_INFO: begin
				hdr_cnt--;
				if (hdr_cnt == 0)
					phase = HUNT_EMPTY;
			end
			READ_HEADER: begin
				case (hdr_cnt)
					8'd1: lsn = b;
					8'd2: fsa[7:0] = b;
					8'd3: fsa[15:8] = b;
					8'd4: lsa[7:0] = b;
					8'd5: lsa[15:8] = b;
					default: ;
				endcase
				hdr_cnt++;
				if (hdr_cnt >= 8) begin
					smp_cnt = '0;
					phase = (lsn == 0) ? HUNT_EMPTY : DIST_LO;
				end
			end
			DIST_LO: begin
				dist_lo = b;
				phase = DIST_HI;
			end
			DIST_HI: begin
				smp_cnt++;
				s = build_sample({b, dist_lo});
				phase = (smp_cnt >= lsn) ? HUNT_EMPTY : DIST_LO;
				return 1'b1;
			end
			default: phase = HUNT_EMPTY;
		endcase
		return 1'b0;
	endfunction

	task automatic report(string what, longint got, longint exp);
		errors++;
		if (errors <= 30)
			$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, exp, cycles);
	endtask

	// one byte transfer on the rx channel
	task automatic send_row(stim_row_t row);
		sample_t s;
		rx_byte <= row.b;
		rx_valid <= 1'b1;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		bytes_sent++;
		if (parse_byte(row.b, s))
			expected_samples.push_back(row.typed ? row.r : s);
	endtask

	int burst_left = 0;

	task automatic send_byte(logic [7:0] b);
		stim_row_t row;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				rx_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		row.b = b;
		row.typed = 1'b0;
		row.r = '{default: '0};
		send_row(row);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_PACKET_HEADER: scan_hdr = data;
			CFG_INFO_HEADER:   info_hdr = data;
			CFG_INFO_SKIP_LEN: skip_len = data[7:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		rx_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_distance();
		case ($urandom_range(0, 9))
			0, 1:    return 16'd0;
			2:       return 16'hFFFF;
			3:       return 16'($urandom_range(1, 4));
			4, 5, 6: return 16'($urandom_range(400, 900));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_angle_word();
		return $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 46079));
	endfunction

	task automatic send_scan_packet();
		logic [15:0] w, d;
		int n;
		case ($urandom_range(0, 99))
			0:                n = 255;
			1, 2, 3, 4, 5, 6: n = 0;
			7, 8, 9, 10, 11:  n = 1;
			default:          n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
						: $urandom_range(2, 6);
		endcase
		scan_pkts++;
		send_byte(scan_hdr[15:8]);
		send_byte(scan_hdr[7:0]);
		send_byte(8'($urandom));
		send_byte(8'(n));
		w = pick_angle_word();
		send_byte(w[7:0]);
		send_byte(w[15:8]);
		w = pick_angle_word();
		send_byte(w[7:0]);
		send_byte(w[15:8]);
		send_byte(8'($urandom));
		send_byte(8'($urandom));
		for (int i = 0; i < n; i++) begin
			d = pick_distance();
			send_byte(d[7:0]);
			send_byte(d[15:8]);
		end
	endtask

	task automatic run_stream(int nbytes);
		int k, start;
		start = bytes_sent;
		while (bytes_sent - start < nbytes) begin
			k = $urandom_range(0, 99);
			if (k < 75)
				send_scan_packet();
			else if (k < 87) begin
				info_pkts++;
				send_byte(info_hdr[15:8]);
				send_byte(info_hdr[7:0]);
				for (int i = 2; i < skip_len; i++)
					send_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end
		end
	endtask

	// receiver: stall pattern changes mode now and then; a hold-off overrides it
	initial begin
		int mode_left, mode;
		mode_left = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				sample_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(50, 400);
					mode = $urandom_range(0, 2);
				end
				mode_left--;
				case (mode)
					0:       sample_stall <= 1'b0;
					1:       sample_stall <= ($urandom_range(0, 9) < 3);
					default: sample_stall <= ($urandom_range(0, 9) < 8);
				endcase
			end
		end
	end

	// result check on every sample transfer
	always @(posedge clk) begin
		sample_t e;
		if (sample_valid && !sample_stall) begin
			samples_seen++;
			if (expected_samples.size() == 0)
				report("unexpected sample", sample_number, 0);
			else begin
				e = expected_samples.pop_front();
				if (distance_raw !== e.dist_raw)
					report("distance_raw", distance_raw, e.dist_raw);
				if (angle_q6 !== e.angle) report("angle_q6", angle_q6, e.angle);
				if (angle_bin !== e.bin) report("angle_bin", angle_bin, e.bin);
				if (sample_number !== e.num) report("sample_number", sample_number, e.num);
				if (last_in_packet !== e.last)
					report("last_in_packet", last_in_packet, e.last);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d samples pending", cycles,
				expected_samples.size());
			$display("Verification failed");
			$finish;
		end
	end

	// directed: header right at stream start, one-sample packet with zero
	// distance (angle is the first angle word, bit 0 dropped), then an empty one
	stim_row_t directed[] = '{
		'{8'h55, 0, '{default: '0}}, '{8'hAA, 0, '{default: '0}},
		'{8'h00, 0, '{default: '0}}, '{8'h01, 0, '{default: '0}},
		'{8'h01, 0, '{default: '0}}, '{8'h5A, 0, '{default: '0}},
		'{8'h00, 0, '{default: '0}}, '{8'h00, 0, '{default: '0}},
		'{8'hFF, 0, '{default: '0}}, '{8'hFF, 0, '{default: '0}},
		'{8'h00, 0, '{default: '0}},
		'{8'h00, 1, '{16'd0, 15'd11520, 9'd180, 8'd1, 1'b1}},
		'{8'h55, 0, '{default: '0}}, '{8'hAA, 0, '{default: '0}},
		'{8'h00, 0, '{default: '0}}, '{8'h00, 0, '{default: '0}},
		'{8'h00, 0, '{default: '0}}, '{8'h00, 0, '{default: '0}},
		'{8'h00, 0, '{default: '0}}, '{8'h00, 0, '{default: '0}},
		'{8'h00, 0, '{default: '0}}, '{8'h00, 0, '{default: '0}}
	};

	logic [15:0] phase_cfg[5][3] = '{
		'{16'h55AA, 16'hA55A, 16'd25},
		'{16'h0000, 16'hFFFF, 16'd2},
		'{16'hFFFF, 16'h0000, 16'd255},
		'{16'h1234, 16'h1234, 16'd7},   // equal headers: info wins
		'{16'h55AA, 16'hA55A, 16'd25}
	};

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_row(directed[i]);
		for (int p = 0; p < 5; p++) begin
			wait_idle();
			if (p == 4) begin
				phase_cfg[p][0] = 16'($urandom);
				phase_cfg[p][1] = 16'($urandom);
				phase_cfg[p][2] = 16'($urandom_range(2, 255));
			end
			cfg_write(CFG_PACKET_HEADER, phase_cfg[p][0]);
			cfg_write(CFG_INFO_HEADER, phase_cfg[p][1]);
			cfg_write(CFG_INFO_SKIP_LEN, phase_cfg[p][2]);
			if (p == 4)
				hold_cycles = HOLD_LEN;
			run_stream(300);
		end
		wait_idle();
		$display("Sent %0d bytes: %0d scan packets, %0d info packets, noise in between",
			bytes_sent, scan_pkts, info_pkts);
		$display("Checked %0d samples over 5 register settings", samples_seen);
		if (errors == 0 && expected_samples.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
